### rtl/bcm_pkg.sv
// Package for the banked cartridge mapper: payload structs, controller
// state and command types, address region bounds and store geometry.
// No dependencies; every file of the block but bcm_ram uses it.
package bcm_pkg;

  // Store geometry: one 8 KiB window per bank, up to sixteen banks.
  localparam int RAM_BANK_BITS    = 4;
  localparam int BANK_OFFSET_BITS = 13;
  localparam int BANK_REG_BITS    = 4;
  localparam int STORE_ADDR_W     = RAM_BANK_BITS + BANK_OFFSET_BITS;
  localparam int STORE_DEPTH      = 1 << STORE_ADDR_W;
  localparam int FULL_ADDR_W      = BANK_REG_BITS + BANK_OFFSET_BITS;

  // Access kinds.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Upper bounds of the write regions, and both bounds of the external RAM window.
  localparam logic [15:0] RAM_EN_LAST   = 16'h1FFF;
  localparam logic [15:0] ROM_LO_LAST   = 16'h2FFF;
  localparam logic [15:0] ROM_HI_LAST   = 16'h3FFF;
  localparam logic [15:0] RAM_BANK_LAST = 16'h5FFF;
  localparam logic [15:0] RAM_WIN_FIRST = 16'hA000;
  localparam logic [15:0] RAM_WIN_LAST  = 16'hBFFF;

  // Enable bits that must all be set for RAM to be reported as switched on.
  localparam logic [7:0] RAM_ON_MASK = 8'h0A;

  typedef struct packed {
    logic        req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
  } in_t;

  typedef struct packed {
    logic       handled;
    logic [7:0] read_byte;
    logic [8:0] rom_bank_now;
    logic [3:0] ram_bank_now;
    logic       ram_on;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

### rtl/bcm_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module bcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/bcm_ctrl.sv
// Controller of the banked cartridge mapper: sequences accept, execute
// and result phases. Depends on bcm_pkg.
module bcm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output bcm_pkg::cmd_t cmd
);

  bcm_pkg::state_t state_r, state_nxt;
  logic            take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A new item may enter while idle, or as the current result leaves.
  always_comb begin
    in_stall = 1'b1;
    unique case (state_r)
      bcm_pkg::ST_IDLE: in_stall = 1'b0;
      bcm_pkg::ST_OUT:  in_stall = out_stall;
      default:          in_stall = 1'b1;
    endcase
  end

  assign take = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcm_pkg::ST_IDLE: begin
        if (take) state_nxt = bcm_pkg::ST_EXEC;
      end
      bcm_pkg::ST_EXEC: state_nxt = bcm_pkg::ST_OUT;
      bcm_pkg::ST_OUT: begin
        if (take) begin
          state_nxt = bcm_pkg::ST_EXEC;
        end else if (!out_stall) begin
          state_nxt = bcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load  = take;
    cmd.exec  = (state_r == bcm_pkg::ST_EXEC);
    out_valid = (state_r == bcm_pkg::ST_OUT);
  end

endmodule

### rtl/bcm_dp.sv
// Datapath of the banked cartridge mapper: request register, address
// decode, banking registers and the external RAM. Depends on bcm_pkg, bcm_ram.
module bcm_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  bcm_pkg::cmd_t cmd,
  input  bcm_pkg::in_t  in_data,
  output bcm_pkg::out_t out_data
);

  bcm_pkg::in_t req_r;
  logic [7:0]   enable_r, enable_nxt;
  logic [7:0]   rom_lo_r, rom_lo_nxt;
  logic         rom_hi_r, rom_hi_nxt;
  logic [3:0]   ram_bank_r, ram_bank_nxt;
  logic         handled_r, handled_nxt;
  logic         rd_sel_r, rd_sel_nxt;

  logic                                  in_ram;
  logic [15:0]                           off_full;
  logic [bcm_pkg::FULL_ADDR_W-1:0]       full_addr;
  logic                                  ram_en;
  logic                                  ram_we;
  logic [7:0]                            ram_rdata;

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
  end

  assign in_ram    = (req_r.bus_address >= bcm_pkg::RAM_WIN_FIRST) &&
                     (req_r.bus_address <= bcm_pkg::RAM_WIN_LAST);
  assign off_full  = req_r.bus_address - bcm_pkg::RAM_WIN_FIRST;
  assign full_addr = {ram_bank_r, off_full[bcm_pkg::BANK_OFFSET_BITS-1:0]};

  always_comb begin
    enable_nxt   = enable_r;
    rom_lo_nxt   = rom_lo_r;
    rom_hi_nxt   = rom_hi_r;
    ram_bank_nxt = ram_bank_r;
    handled_nxt  = handled_r;
    rd_sel_nxt   = rd_sel_r;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    if (cmd.exec) begin
      handled_nxt = 1'b0;
      rd_sel_nxt  = 1'b0;
      if (req_r.req_type == bcm_pkg::REQ_WRITE) begin
        priority if (req_r.bus_address <= bcm_pkg::RAM_EN_LAST) begin
          enable_nxt  = req_r.write_byte;
          handled_nxt = 1'b1;
        end else if (req_r.bus_address <= bcm_pkg::ROM_LO_LAST) begin
          rom_lo_nxt  = req_r.write_byte;
          handled_nxt = 1'b1;
        end else if (req_r.bus_address <= bcm_pkg::ROM_HI_LAST) begin
          rom_hi_nxt  = req_r.write_byte[0];
          handled_nxt = 1'b1;
        end else if (req_r.bus_address <= bcm_pkg::RAM_BANK_LAST) begin
          ram_bank_nxt = req_r.write_byte[3:0];
          handled_nxt  = 1'b1;
        end else if (in_ram) begin
          ram_en      = 1'b1;
          ram_we      = 1'b1;
          handled_nxt = 1'b1;
        end else begin
          handled_nxt = 1'b0;
        end
      end else if (in_ram) begin
        ram_en      = 1'b1;
        handled_nxt = 1'b1;
        rd_sel_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= '0;
      rom_lo_r   <= '0;
      rom_hi_r   <= 1'b0;
      ram_bank_r <= '0;
      handled_r  <= 1'b0;
      rd_sel_r   <= 1'b0;
    end else begin
      enable_r   <= enable_nxt;
      rom_lo_r   <= rom_lo_nxt;
      rom_hi_r   <= rom_hi_nxt;
      ram_bank_r <= ram_bank_nxt;
      handled_r  <= handled_nxt;
      rd_sel_r   <= rd_sel_nxt;
    end
  end

  bcm_ram #(
    .WIDTH(8),
    .DEPTH(bcm_pkg::STORE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (full_addr[bcm_pkg::STORE_ADDR_W-1:0]),
    .wdata(req_r.write_byte),
    .rdata(ram_rdata)
  );

  // The RAM read data holds until the next RAM read, so it is valid for
  // as long as the result waits.
  always_comb begin
    out_data.handled      = handled_r;
    out_data.read_byte    = rd_sel_r ? ram_rdata : 8'h00;
    out_data.rom_bank_now = {rom_hi_r, rom_lo_r};
    out_data.ram_bank_now = ram_bank_r;
    out_data.ram_on       = ((enable_r & bcm_pkg::RAM_ON_MASK) == bcm_pkg::RAM_ON_MASK);
  end

endmodule

### rtl/banked_cartridge_mapper_unit.sv
// Banked cartridge mapper: top level joining controller and datapath.
// Each accepted item passes through the execute state, and its result is
// then offered in the output state. No item is taken during execute; the
// next may enter as the result leaves, and a stalled result holds it back.
// Reset (rst_n low, synchronous) clears the banking registers and the
// controller; external RAM contents are undefined until written.
module banked_cartridge_mapper_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bcm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bcm_pkg::out_t out_data
);

  // Commands travel from the controller to the datapath as one struct.
  bcm_pkg::cmd_t cmd;

  // The controller decides when an item is taken, when it is executed and
  // when its result is offered on the output channel.
  bcm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  // The datapath holds the request, the banking registers and the RAM, and
  // keeps the result steady while the output is stalled.
  bcm_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .out_data(out_data)
  );

`ifndef SYNTHESIS
  // Every accepted item is followed by its result, offered after the execute state.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("result did not follow an accepted item");

  // No item is taken while the previous one is still executing.
  a_no_take_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> in_stall)
    else $error("item accepted during execute");

  // An unhandled access never returns RAM data.
  a_unhandled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.handled) |-> (out_data.read_byte == 8'h00))
    else $error("unhandled access returned a data byte");
`endif

endmodule
